[rtl/tagged_track_slot_manager_core_assert.svh]
// Assertion helpers for the track slot manager.
`ifndef TAGGED_TRACK_SLOT_MANAGER_CORE_ASSERT_SVH
`define TAGGED_TRACK_SLOT_MANAGER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttsm assertion failed");

// Next-cycle implication, checked outside reset.
`define TTSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttsm assertion failed");

`endif

[rtl/ttsm_pkg.sv]
package ttsm_pkg;

  localparam int MAX_TRACKS_DEF = 4;
  localparam int CMD_Q_DEPTH    = 2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pos_t;

  typedef struct packed {
    logic               target_present;
    logic [31:0]        target_key;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
    logic [31:0]        frame_time;
    logic               last_target;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         slot_number;
    logic [31:0]        track_id;
    logic [31:0]        track_key;
    logic signed [15:0] track_x;
    logic signed [15:0] track_y;
    logic signed [15:0] track_z;
    logic [31:0]        echo_time;
    logic               last_track;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic        do_target;
    logic        last;
    logic        en;
    logic [31:0] key;
    pos_t        pos;
    logic [31:0] frame_time;
  } cmd_t;

endpackage

[rtl/ttsm_front.sv]
module ttsm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               push,
  output logic               full,
  input  ttsm_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               q_push,
  output ttsm_pkg::cmd_t     q_cmd
);

  logic enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      enable_r <= cfg_wdata;
    end
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

  // Disabled or absent targets leave the table alone.
  always_comb begin
    q_cmd.do_target  = enable_r && in_item.target_present;
    q_cmd.last       = in_item.last_target;
    q_cmd.en         = enable_r;
    q_cmd.key        = in_item.target_key;
    q_cmd.pos.x      = in_item.target_x;
    q_cmd.pos.y      = in_item.target_y;
    q_cmd.pos.z      = in_item.target_z;
    q_cmd.frame_time = in_item.frame_time;
  end

endmodule

[rtl/ttsm_cmd_fifo.sv]
module ttsm_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  ttsm_pkg::cmd_t wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output logic           q_empty,
  output ttsm_pkg::cmd_t rd_data
);

  localparam int DEPTH = ttsm_pkg::CMD_Q_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ttsm_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign q_full  = (cnt_r == CNT_W'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/ttsm_back.sv]
module ttsm_back #(
  parameter int MAX_TRACKS = ttsm_pkg::MAX_TRACKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ttsm_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output ttsm_pkg::out_item_t out_item
);

  `include "tagged_track_slot_manager_core_assert.svh"

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TRACKS - 1);

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t state_r;
  logic [IDX_W-1:0] emit_idx_r;
  logic [31:0] emit_time_r;
  logic emit_en_r;
  logic out_valid_r;
  ttsm_pkg::out_item_t out_r;

  logic [MAX_TRACKS-1:0] used_r, used_nxt;
  logic [MAX_TRACKS-1:0] seen_r, seen_nxt;
  logic [31:0] key_r [MAX_TRACKS];
  logic [31:0] key_nxt [MAX_TRACKS];
  logic [31:0] id_r [MAX_TRACKS];
  logic [31:0] id_nxt [MAX_TRACKS];
  ttsm_pkg::pos_t pos_r [MAX_TRACKS];
  ttsm_pkg::pos_t pos_nxt [MAX_TRACKS];
  logic [31:0] cnt_r, cnt_nxt;

  logic [MAX_TRACKS-1:0] hit;
  logic any_hit;
  logic any_free;
  logic [IDX_W-1:0] free_idx;
  logic emit_load;
  logic ids_clean;
  ttsm_pkg::out_item_t emit_item;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign empty     = !out_valid_r;
  assign out_item  = out_r;
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || pop);

  always_comb begin
    hit      = '0;
    any_free = 1'b0;
    free_idx = '0;
    ids_clean = 1'b1;
    for (int k = MAX_TRACKS - 1; k >= 0; k--) begin
      hit[k] = used_r[k] && (key_r[k] == q_cmd.key);
      if (!used_r[k]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(k);
      end
      if (!used_r[k] && (id_r[k] != '0)) begin
        ids_clean = 1'b0;
      end
    end
    any_hit = |hit;
  end

  // Target update first, then frame close on the same command.
  always_comb begin
    used_nxt = used_r;
    seen_nxt = seen_r;
    key_nxt  = key_r;
    id_nxt   = id_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    if (q_pop && q_cmd.do_target) begin
      if (any_hit) begin
        seen_nxt = seen_r | hit;
      end else if (any_free) begin
        cnt_nxt            = cnt_r + 32'd1;
        used_nxt[free_idx] = 1'b1;
        seen_nxt[free_idx] = 1'b1;
        key_nxt[free_idx]  = q_cmd.key;
        id_nxt[free_idx]   = cnt_r + 32'd1;
        pos_nxt[free_idx]  = q_cmd.pos;
      end
    end
    if (q_pop && q_cmd.last && q_cmd.en) begin
      for (int k = 0; k < MAX_TRACKS; k++) begin
        if (used_nxt[k] && !seen_nxt[k]) begin
          used_nxt[k] = 1'b0;
          id_nxt[k]   = '0;
        end
        seen_nxt[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      seen_r <= '0;
      cnt_r  <= '0;
      for (int k = 0; k < MAX_TRACKS; k++) begin
        id_r[k]  <= '0;
        pos_r[k] <= '0;
      end
    end else begin
      used_r <= used_nxt;
      seen_r <= seen_nxt;
      cnt_r  <= cnt_nxt;
      id_r   <= id_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_comb begin
    emit_item.slot_number = 4'(emit_idx_r);
    emit_item.track_id    = (emit_en_r && used_r[emit_idx_r]) ? id_r[emit_idx_r] : '0;
    emit_item.track_key   = (emit_en_r && used_r[emit_idx_r]) ? key_r[emit_idx_r] : '0;
    emit_item.track_x     = emit_en_r ? pos_r[emit_idx_r].x : '0;
    emit_item.track_y     = emit_en_r ? pos_r[emit_idx_r].y : '0;
    emit_item.track_z     = emit_en_r ? pos_r[emit_idx_r].z : '0;
    emit_item.echo_time   = emit_time_r;
    emit_item.last_track  = (emit_idx_r == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            out_valid_r <= 1'b0;
          end
          if (q_pop && q_cmd.last) begin
            state_r     <= ST_EMIT;
            emit_idx_r  <= '0;
            emit_time_r <= q_cmd.frame_time;
            emit_en_r   <= q_cmd.en;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_r       <= emit_item;
            out_valid_r <= 1'b1;
            if (emit_idx_r == LAST_IDX) begin
              state_r <= ST_IDLE;
            end else begin
              emit_idx_r <= emit_idx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `TTSM_ASSERT_NEXT(a_last_load_to_idle,
    emit_load && (emit_idx_r == LAST_IDX),
    (state_r == ST_IDLE) && out_valid_r && out_r.last_track)
  `TTSM_ASSERT_NEXT(a_frame_end_starts_emit, q_pop && q_cmd.last,
    (state_r == ST_EMIT) && (emit_idx_r == '0))
  `TTSM_ASSERT_NOW(a_last_beat_slot, out_valid_r && out_r.last_track,
    out_r.slot_number == 4'(MAX_TRACKS - 1))
  `TTSM_ASSERT_NOW(a_free_slot_id_zero, 1'b1, ids_clean)

endmodule

[rtl/tagged_track_slot_manager_core.sv]
// Channel   Handshake             Payload
// input     push / full           in_item  (ttsm_pkg::in_item_t)
// result    empty / pop           out_item (ttsm_pkg::out_item_t)
// config    cfg_we                cfg_wdata (enable)
//
// A target that is not the last of its frame is applied to the table as it leaves the queue.
// The last target adds MAX_TRACKS slot beats: one slot beat per cycle while the result is popped.
// A two-entry command queue lets input keep flowing while the table is emitted.
// Result stalls hold the slot sequencer; the queue fills and then raises full.
// Synchronous active-low reset clears the table flags, ids, positions and counter.
module tagged_track_slot_manager_core #(
  parameter int MAX_TRACKS = ttsm_pkg::MAX_TRACKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                push,
  output logic                full,
  input  ttsm_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output ttsm_pkg::out_item_t out_item
);

  ttsm_pkg::cmd_t push_cmd;
  ttsm_pkg::cmd_t head_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  ttsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  ttsm_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_data(push_cmd),
    .q_full (q_full),
    .rd_en  (q_pop),
    .q_empty(q_empty),
    .rd_data(head_cmd)
  );

  ttsm_back #(
    .MAX_TRACKS(MAX_TRACKS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

endmodule

[tb/sv/tb_tagged_track_slot_manager_core.sv]
module tb_tagged_track_slot_manager_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRACKS = ttsm_pkg::MAX_TRACKS_DEF;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_wdata;
  logic                push;
  logic                full;
  ttsm_pkg::in_item_t  in_item;
  logic                empty;
  logic                pop;
  ttsm_pkg::out_item_t out_item;

  bit          jitter_on;
  int          rx_hold_req;
  int          counted;
  int          settings_written;
  logic [31:0] key_pool [6];

  // Slot table predictor plus the queue of track beats it still owes.
  class track_table_scoreboard;
    bit                  enabled;
    bit                  used [TRACKS];
    bit                  seen [TRACKS];
    logic [31:0]         key  [TRACKS];
    logic [31:0]         id   [TRACKS];
    ttsm_pkg::pos_t      pos  [TRACKS];
    logic [31:0]         id_count;
    ttsm_pkg::out_item_t tracks_due [$];
    int                  errors;
    int                  frames;
    int                  beats;
    int                  new_tracks;
    int                  reseen;
    int                  dropped;

    function new();
      for (int k = 0; k < TRACKS; k++) begin
        used[k] = 0;
        seen[k] = 0;
        key[k]  = '0;
        id[k]   = '0;
        pos[k]  = '0;
      end
      id_count = '0;
      enabled  = 0;
    endfunction

    function void note_target(ttsm_pkg::in_item_t t);
      bit                  done;
      ttsm_pkg::out_item_t r;
      if (enabled && t.target_present) begin
        done = 0;
        for (int k = 0; k < TRACKS; k++) begin
          if (!done && used[k] && key[k] == t.target_key) begin
            seen[k] = 1;
            done    = 1;
            reseen++;
          end
        end
        for (int k = 0; k < TRACKS; k++) begin
          if (!done && !used[k]) begin
            id_count = id_count + 32'd1;
            used[k]  = 1;
            key[k]   = t.target_key;
            id[k]    = id_count;
            pos[k].x = t.target_x;
            pos[k].y = t.target_y;
            pos[k].z = t.target_z;
            seen[k]  = 1;
            done     = 1;
            new_tracks++;
          end
        end
        if (!done) dropped++;
      end
      if (!t.last_target) return;
      frames++;
      // free what went unseen; a disabled frame keeps its marks
      if (enabled) begin
        for (int k = 0; k < TRACKS; k++) begin
          if (used[k] && !seen[k]) begin
            used[k] = 0;
            id[k]   = '0;
          end
          seen[k] = 0;
        end
      end
      for (int k = 0; k < TRACKS; k++) begin
        r.slot_number = k[3:0];
        r.track_id    = (enabled && used[k]) ? id[k] : '0;
        r.track_key   = (enabled && used[k]) ? key[k] : '0;
        r.track_x     = enabled ? pos[k].x : '0;
        r.track_y     = enabled ? pos[k].y : '0;
        r.track_z     = enabled ? pos[k].z : '0;
        r.echo_time   = t.frame_time;
        r.last_track  = (k == TRACKS - 1);
        tracks_due.push_back(r);
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_track(ttsm_pkg::out_item_t got);
      ttsm_pkg::out_item_t want;
      beats++;
      if (tracks_due.size() == 0) begin
        report($sformatf("track beat for slot %0d with nothing pending", got.slot_number));
        return;
      end
      want = tracks_due.pop_front();
      if (got.slot_number !== want.slot_number)
        report($sformatf("slot_number %0d, want %0d", got.slot_number, want.slot_number));
      if (got.track_id !== want.track_id)
        report($sformatf("slot %0d track_id %h, want %h", want.slot_number, got.track_id,
                         want.track_id));
      if (got.track_key !== want.track_key)
        report($sformatf("slot %0d track_key %h, want %h", want.slot_number, got.track_key,
                         want.track_key));
      if (got.track_x !== want.track_x)
        report($sformatf("slot %0d track_x %0d, want %0d", want.slot_number, got.track_x,
                         want.track_x));
      if (got.track_y !== want.track_y)
        report($sformatf("slot %0d track_y %0d, want %0d", want.slot_number, got.track_y,
                         want.track_y));
      if (got.track_z !== want.track_z)
        report($sformatf("slot %0d track_z %0d, want %0d", want.slot_number, got.track_z,
                         want.track_z));
      if (got.echo_time !== want.echo_time)
        report($sformatf("slot %0d echo_time %h, want %h", want.slot_number, got.echo_time,
                         want.echo_time));
      if (got.last_track !== want.last_track)
        report($sformatf("slot %0d last_track %b, want %b", want.slot_number, got.last_track,
                         want.last_track));
    endtask
  endclass

  track_table_scoreboard sb = new();

  tagged_track_slot_manager_core #(
    .MAX_TRACKS(TRACKS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d track beats pending", sb.tracks_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (!jitter_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ttsm_pkg::in_item_t tgt(bit present, logic [31:0] k,
                                             logic signed [15:0] x,
                                             logic signed [15:0] y,
                                             logic signed [15:0] z,
                                             logic [31:0] stamp, bit last);
    ttsm_pkg::in_item_t it;
    it.target_present = present;
    it.target_key     = k;
    it.target_x       = x;
    it.target_y       = y;
    it.target_z       = z;
    it.frame_time     = stamp;
    it.last_target    = last;
    return it;
  endfunction

  task automatic push_target(ttsm_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push    <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    sb.note_target(it);
    if ((it.target_present && sb.enabled) || it.last_target) counted++;
  endtask

  // Hold the sender until every owed beat is back, then let in-flight targets retire.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.tracks_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_enable(bit v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.enabled = v;
    settings_written++;
  endtask

  task automatic send_frame(bit tidy);
    int                 n;
    logic [31:0]        stamp;
    ttsm_pkg::in_item_t it;
    n     = tidy ? $urandom_range(1, 6) : $urandom_range(1, 4);
    stamp = $urandom;
    if ($urandom_range(0, 3) == 0) key_pool[$urandom_range(0, 5)] = $urandom;
    for (int i = 0; i < n; i++) begin
      it.target_present = tidy ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 1) != 0);
      it.target_key     = (tidy && $urandom_range(0, 7) != 0) ? key_pool[$urandom_range(0, 5)]
                                                              : $urandom;
      it.target_x       = 16'($urandom);
      it.target_y       = 16'($urandom);
      it.target_z       = 16'($urandom);
      it.frame_time     = tidy ? stamp : $urandom;
      it.last_target    = tidy ? (i == n - 1) : ($urandom_range(0, 2) == 0);
      push_target(it);
    end
  endtask

  initial begin : result_side
    int hold;
    hold = 0;
    pop  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 4) == 0) hold = pick_gap();
      end
      @(posedge clk);
      if (pop && !empty) sb.check_track(out_item);
    end
  end

  initial begin : target_side
    rst_n            = 1'b0;
    push             = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_item          = '0;
    counted          = 0;
    settings_written = 0;
    rx_hold_req      = 0;
    jitter_on        = 1;
    for (int i = 0; i < 6; i++) key_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // disabled out of reset: the table reads back empty
    push_target(tgt(1'b1, 32'h1234_5678, 16'sd100, -16'sd100, 16'sd7, 32'h0000_0001, 1'b1));
    settle();
    write_enable(1'b1);
    push_target(tgt(1'b1, 32'h0000_0000, 16'sh8000, 16'sd32767, 16'sd0, 32'h0, 1'b0));
    push_target(tgt(1'b1, 32'hFFFF_FFFF, 16'sd32767, 16'sh8000, -16'sd1, 32'h0, 1'b0));
    // repeat key: mark seen, keep the first position
    push_target(tgt(1'b1, 32'h0000_0000, 16'sd1, 16'sd2, 16'sd3, 32'h0, 1'b0));
    push_target(tgt(1'b0, $urandom, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                    1'b0));
    push_target(tgt(1'b1, 32'hA5A5_A5A5, 16'sd11, 16'sd12, 16'sd13, 32'h0, 1'b0));
    push_target(tgt(1'b1, 32'h5A5A_5A5A, 16'sd21, 16'sd22, 16'sd23, 32'h0, 1'b0));
    // table full: drop the rest, including the last one
    push_target(tgt(1'b1, 32'h0F0F_0F0F, 16'sd31, 16'sd32, 16'sd33, 32'h0, 1'b0));
    push_target(tgt(1'b1, 32'hF0F0_F0F0, 16'sd41, 16'sd42, 16'sd43, 32'hFFFF_FFFF, 1'b1));
    // keep two, free the others; absent last still closes the frame
    push_target(tgt(1'b1, 32'h0000_0000, 16'sd5, 16'sd5, 16'sd5, 32'h0, 1'b0));
    push_target(tgt(1'b1, 32'h5A5A_5A5A, 16'sd6, 16'sd6, 16'sd6, 32'h0, 1'b0));
    push_target(tgt(1'b0, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                    32'h8000_0000, 1'b1));
    // new key takes the lowest free slot
    push_target(tgt(1'b1, 32'hC3C3_C3C3, 16'sd51, 16'sd52, 16'sd53, 32'h0, 1'b0));
    push_target(tgt(1'b1, 32'h0000_0000, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0));
    push_target(tgt(1'b1, 32'h5A5A_5A5A, 16'sd0, 16'sd0, 16'sd0, 32'h7FFF_FFFF, 1'b1));
    // set a mark, close the frame while disabled, then check the mark survived
    push_target(tgt(1'b1, 32'hC3C3_C3C3, 16'sd9, 16'sd9, 16'sd9, 32'h0, 1'b0));
    settle();
    write_enable(1'b0);
    push_target(tgt(1'b1, 32'h7777_7777, 16'sd1, 16'sd1, 16'sd1, 32'h0000_0042, 1'b1));
    settle();
    write_enable(1'b1);
    push_target(tgt(1'b0, 32'h0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0043, 1'b1));

    for (int p = 0; p < 6; p++) begin
      bit en_phase;
      int goal;
      en_phase = (p != 3);
      settle();
      write_enable(en_phase);
      jitter_on = (p != 1);
      // long receiver stall: the block must fill and push back
      if (p == 2) rx_hold_req = 400;
      goal = counted + 75;
      if (!en_phase) repeat (8) send_frame(1'b1);
      else while (counted < goal) send_frame($urandom_range(0, 3) != 0);
    end
    settle();

    $display("%0d frames, %0d track beats, %0d enable writes", sb.frames, sb.beats,
             settings_written);
    $display("%0d new tracks, %0d re-seen targets, %0d dropped on a full table",
             sb.new_tracks, sb.reseen, sb.dropped);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
